// ===== hw/rtl/winding_number_point_in_polygon_defines.svh =====
// Assertion helpers for the checker of this block.
// Both sample on the rising edge of clk and stay off while rst is high.
`ifndef WINDING_NUMBER_POINT_IN_POLYGON_DEFINES_SVH
`define WINDING_NUMBER_POINT_IN_POLYGON_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WNPIP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WNPIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/wnpip_pkg.sv =====
package wnpip_pkg;

  localparam int MAX_VERTS_DEF  = 256;
  localparam int COORD_BITS_DEF = 32;

  localparam int FIELD_W     = 32;
  localparam int COORD_TOL_W = 31;
  localparam int CROSS_TOL_W = 62;
  localparam int WINDING_W   = 9;
  localparam int WINDING_MAX = 255;
  localparam int WINDING_MIN = -256;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COORD_TOL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CROSS_TOL = 1'b1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic signed [FIELD_W-1:0] coord_x;
    logic signed [FIELD_W-1:0] coord_y;
    logic                      restart;
  } item_t;

  typedef struct packed {
    logic signed [WINDING_W-1:0] winding;
    logic                        inside_res;
    logic                        overflowed;
  } result_t;

  typedef struct packed {
    logic busy;
    logic step_valid;
    logic inc;
    logic dec;
  } edge_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } wnpip_state_t;

endpackage

// ===== hw/rtl/wnpip_ram.sv =====
module wnpip_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/wnpip_edge.sv =====
module wnpip_edge #(
  parameter int COORD_BITS = wnpip_pkg::COORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      edge_valid,
  input  logic signed [COORD_BITS-1:0]              xi,
  input  logic signed [COORD_BITS-1:0]              yi,
  input  logic signed [COORD_BITS-1:0]              xj,
  input  logic signed [COORD_BITS-1:0]              yj,
  input  logic signed [COORD_BITS-1:0]              px,
  input  logic signed [COORD_BITS-1:0]              py,
  input  logic signed [((COORD_BITS > 31) ? COORD_BITS : 31) + 1:0] ylim,
  input  logic [wnpip_pkg::CROSS_TOL_W-1:0]         cross_tol,
  output wnpip_pkg::edge_out_t                      edge_out
);
  import wnpip_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int YW = ((C > 31) ? C : 31) + 2;
  localparam int DW = C + 1;
  localparam int PW = 2 * DW;
  localparam int XW = (PW + 1 > CROSS_TOL_W + 1) ? PW + 1 : CROSS_TOL_W + 1;

  logic signed [YW-1:0] yi_ext;
  logic signed [YW-1:0] yj_ext;
  logic signed [XW-1:0] tol;

  // stage A: differences and crossing direction
  logic                 va;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dyp;
  logic signed [DW-1:0] ex;
  logic signed [DW-1:0] ey;
  logic                 up_a;
  logic                 dn_a;

  // stage B: products
  logic                 vb;
  logic signed [PW-1:0] p1;
  logic signed [PW-1:0] p2;
  logic                 up_b;
  logic                 dn_b;

  // stage C: cross product
  logic                 vc;
  logic signed [XW-1:0] xp;
  logic                 up_c;
  logic                 dn_c;

  // stage D: decision
  logic                 vd;
  logic                 inc;
  logic                 dec;

  assign yi_ext = $signed({{(YW - C){yi[C-1]}}, yi});
  assign yj_ext = $signed({{(YW - C){yj[C-1]}}, yj});
  assign tol    = $signed({{(XW - CROSS_TOL_W){1'b0}}, cross_tol});

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      va <= edge_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    dx   <= $signed({xj[C-1], xj}) - $signed({xi[C-1], xi});
    dyp  <= $signed({py[C-1], py}) - $signed({yi[C-1], yi});
    ex   <= $signed({px[C-1], px}) - $signed({xi[C-1], xi});
    ey   <= $signed({yj[C-1], yj}) - $signed({yi[C-1], yi});
    up_a <= (yi_ext <= ylim) && (yj_ext > ylim);
    dn_a <= (yi_ext > ylim) && (yj_ext <= ylim);

    p1   <= PW'(dx) * PW'(dyp);
    p2   <= PW'(ex) * PW'(ey);
    up_b <= up_a;
    dn_b <= dn_a;

    xp   <= XW'(p1) - XW'(p2);
    up_c <= up_b;
    dn_c <= dn_b;

    inc  <= up_c && (xp > tol);
    dec  <= dn_c && (xp < -tol);
  end

  always_comb begin
    edge_out.busy       = va | vb | vc | vd;
    edge_out.step_valid = vd;
    edge_out.inc        = inc;
    edge_out.dec        = dec;
  end

endmodule

// ===== hw/rtl/winding_number_point_in_polygon.sv =====
// Point-in-polygon test by winding number. A load transaction (cmd 0) writes
// one vertex into the vertex RAM; restart begins a new polygon, and vertices past
// MAX_VERTS are dropped with a sticky overflow flag.
// A test transaction (cmd 1) walks the n stored edges, one vertex read per
// cycle from the single RAM read port, through a four-stage edge pipeline
// (differences, two multipliers, cross product, tolerance compare), and
// returns one result after the edge pipeline drains; with no vertices the walk
// and drain are skipped. Input is stalled during a test. The vertex
// RAM is not cleared; only entries below the current count are ever read.
// coord_tolerance is Q16.16, cross_tolerance is Q32.32; the winding number
// saturates to the 9-bit range while inside_res reflects the exact count.
module winding_number_point_in_polygon #(
  parameter int MAX_VERTS  = wnpip_pkg::MAX_VERTS_DEF,
  parameter int COORD_BITS = wnpip_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  wnpip_pkg::item_t                   item_data,
  output logic                               res_valid,
  input  logic                               res_stall,
  output wnpip_pkg::result_t                 res_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wnpip_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wnpip_pkg::CROSS_TOL_W-1:0]  cfg_data
);
  import wnpip_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int AW  = $clog2(MAX_VERTS);
  localparam int CW  = $clog2(MAX_VERTS + 1);
  localparam int YW  = ((C > 31) ? C : 31) + 2;
  localparam int WNW = CW + 1;
  localparam int SW  = (WNW > WINDING_W) ? WNW : WINDING_W;
  localparam logic signed [SW-1:0] WN_HI = SW'(WINDING_MAX);
  localparam logic signed [SW-1:0] WN_LO = SW'(WINDING_MIN);

  wnpip_state_t state;
  wnpip_state_t state_next;

  logic [CW-1:0]          vcount;
  logic                   ovf;
  logic [COORD_TOL_W-1:0] coord_tol;
  logic [CROSS_TOL_W-1:0] cross_tol;

  logic signed [C-1:0]    px;
  logic signed [C-1:0]    py;
  logic signed [YW-1:0]   ylim;
  logic [CW-1:0]          rd_idx;
  logic                   rd_valid;
  logic                   rd_first;
  logic                   rd_close;
  logic signed [C-1:0]    first_x;
  logic signed [C-1:0]    first_y;
  logic signed [C-1:0]    prev_x;
  logic signed [C-1:0]    prev_y;
  logic signed [WNW-1:0]  wn;

  logic                   accept;
  logic                   is_load;
  logic                   is_test;
  logic                   has_room;
  logic                   walk_issue;
  logic                   walk_close;
  logic                   res_load;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [2*C-1:0]         ram_wdata;
  logic                   ram_re;
  logic [2*C-1:0]         ram_rdata;

  logic signed [C-1:0]    in_x;
  logic signed [C-1:0]    in_y;
  logic signed [C-1:0]    cur_x;
  logic signed [C-1:0]    cur_y;
  logic                   edge_valid;
  edge_out_t              edge_out;

  logic signed [SW-1:0]   wn_ext;
  logic signed [SW-1:0]   wn_sat;

  assign cfg_ready = 1'b1;

  assign in_x     = $signed(item_data.coord_x[C-1:0]);
  assign in_y     = $signed(item_data.coord_y[C-1:0]);
  assign accept   = item_valid && !item_stall;
  assign is_load  = accept && (item_data.cmd == CMD_LOAD);
  assign is_test  = accept && (item_data.cmd == CMD_TEST);
  assign has_room = vcount < CW'(MAX_VERTS);

  assign ram_we    = is_load && (item_data.restart || has_room);
  assign ram_waddr = item_data.restart ? '0 : vcount[AW-1:0];
  assign ram_wdata = {in_x, in_y};

  wnpip_ram #(
    .WIDTH (2 * C),
    .DEPTH (MAX_VERTS)
  ) u_vert_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // the closing edge reuses vertex 0 instead of a RAM read
  assign cur_x      = rd_close ? first_x : $signed(ram_rdata[2*C-1:C]);
  assign cur_y      = rd_close ? first_y : $signed(ram_rdata[C-1:0]);
  assign edge_valid = rd_valid && !rd_first;

  wnpip_edge #(
    .COORD_BITS (C)
  ) u_edge (
    .clk        (clk),
    .rst        (rst),
    .edge_valid (edge_valid),
    .xi         (prev_x),
    .yi         (prev_y),
    .xj         (cur_x),
    .yj         (cur_y),
    .px         (px),
    .py         (py),
    .ylim       (ylim),
    .cross_tol  (cross_tol),
    .edge_out   (edge_out)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (is_test) begin
          state_next = (vcount == '0) ? ST_FINISH : ST_WALK;
        end
      end
      ST_WALK: begin
        if (rd_idx == vcount) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid && !edge_out.busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!res_valid || !res_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    item_stall = (state != ST_IDLE);
    walk_issue = (state == ST_WALK);
    walk_close = walk_issue && (rd_idx == vcount);
    ram_re     = walk_issue && !walk_close;
    res_load   = (state == ST_FINISH) && (!res_valid || !res_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vcount    <= '0;
      ovf       <= 1'b0;
      coord_tol <= '0;
      cross_tol <= '0;
      rd_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= walk_issue;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COORD_TOL: coord_tol <= cfg_data[COORD_TOL_W-1:0];
          CFG_CROSS_TOL: cross_tol <= cfg_data;
          default: ;
        endcase
      end
      if (is_load) begin
        if (item_data.restart) begin
          vcount <= CW'(1);
          ovf    <= 1'b0;
        end else if (has_room) begin
          vcount <= vcount + CW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_first <= walk_issue && !walk_close && (rd_idx == '0);
    rd_close <= walk_close;
    if (is_test) begin
      px     <= in_x;
      py     <= in_y;
      ylim   <= $signed(YW'(in_y)) + $signed({{(YW - COORD_TOL_W){1'b0}}, coord_tol});
      rd_idx <= '0;
    end else if (walk_issue) begin
      rd_idx <= rd_idx + CW'(1);
    end
    if (rd_valid) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    if (rd_valid && rd_first) begin
      first_x <= cur_x;
      first_y <= cur_y;
    end
    if (is_test) begin
      wn <= '0;
    end else if (edge_out.step_valid && edge_out.inc) begin
      wn <= wn + WNW'(1);
    end else if (edge_out.step_valid && edge_out.dec) begin
      wn <= wn - WNW'(1);
    end
  end

  // clamp to the 9-bit result range
  always_comb begin
    wn_ext = SW'(wn);
    if (wn_ext > WN_HI) begin
      wn_sat = WN_HI;
    end else if (wn_ext < WN_LO) begin
      wn_sat = WN_LO;
    end else begin
      wn_sat = wn_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_data.winding    <= wn_sat[WINDING_W-1:0];
      res_data.inside_res <= (wn != '0);
      res_data.overflowed <= ovf;
    end
  end

endmodule

// ===== hw/rtl/wnpip_check.sv =====
`include "winding_number_point_in_polygon_defines.svh"

module wnpip_check (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input wnpip_pkg::item_t   item_data,
  input logic               res_valid,
  input logic               res_stall,
  input wnpip_pkg::result_t res_data
);
  import wnpip_pkg::*;

  // hold a stalled result
  `WNPIP_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid,
    "result dropped while stalled")
  `WNPIP_ASSERT_NEXT(a_res_stable, res_valid && res_stall, $stable(res_data),
    "stalled result changed")

  // inside flag must agree with the clamped winding number
  `WNPIP_ASSERT_NOW(a_inside_match, res_valid,
    res_data.inside_res == (res_data.winding != '0),
    "inside flag disagrees with winding number")

  // a test never completes in the cycle after acceptance
  `WNPIP_ASSERT_NEXT(a_test_latency,
    item_valid && !item_stall && (item_data.cmd == CMD_TEST) && !res_valid,
    !res_valid, "test result appeared too early")

endmodule

bind winding_number_point_in_polygon wnpip_check u_check (.*);
